// ===== rtl/bfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the byte frame deframer: framing bytes,
// result kinds, register indexes and the item passed from front to back.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int BYTE_W       = 8;
  localparam int FRAME_LEN_W  = 16;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int QPTR_W       = $clog2(FIFO_DEPTH);
  localparam int QCNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h7f;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h7e;

  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_MODE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_LENGTH = 8'd1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [BYTE_W-1:0]       payload;
    logic [FRAME_LEN_W-1:0]  length;
  } bfd_result_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } bfd_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/bfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_front
// Front end: holds the framing registers, tracks the frame phase for each
// accepted byte and emits payload and frame end items into the queue.
// ----------------------------------------------------------------------------
module bfd_front #(
  parameter int LENGTH_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic [bfd_pkg::BYTE_W-1:0]      rx_byte,
  input  wire logic                            cfg_we,
  input  wire logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 push,
  output bfd_pkg::bfd_result_t                 push_data
);
  import bfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TAIL    = 3'd4
  } phase_t;

  phase_t                  phase, phase_next;
  logic [LENGTH_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [LENGTH_WIDTH-1:0] current_length, current_length_next;
  logic                    length_mode;
  logic [FRAME_LEN_W-1:0]  fixed_length;

  logic                    start_go;
  logic [LENGTH_WIDTH-1:0] start_len;
  logic [FRAME_LEN_W-1:0]  len_pair;
  logic [LENGTH_WIDTH-1:0] left_dec;

  assign len_pair = {rx_byte, current_length[BYTE_W-1:0]};
  assign left_dec = bytes_left - 1'b1;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    current_length_next = current_length;
    start_go            = 1'b0;
    start_len           = '0;
    push                = 1'b0;
    push_data.kind      = KIND_PAYLOAD;
    push_data.payload   = '0;
    push_data.length    = FRAME_LEN_W'(current_length);
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          if (length_mode) begin
            current_length_next = '0;
            bytes_left_next     = '0;
            phase_next          = PH_LEN_LO;
          end else begin
            start_go  = 1'b1;
            start_len = fixed_length[LENGTH_WIDTH-1:0];
          end
        end
      end
      PH_LEN_LO: begin
        // narrow lengths fit in a single byte
        if (LENGTH_WIDTH <= BYTE_W) begin
          start_go  = 1'b1;
          start_len = LENGTH_WIDTH'(rx_byte);
        end else begin
          current_length_next = LENGTH_WIDTH'(rx_byte);
          phase_next          = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        start_go  = 1'b1;
        start_len = len_pair[LENGTH_WIDTH-1:0];
      end
      PH_PAYLOAD: begin
        push              = 1'b1;
        push_data.payload = rx_byte;
        bytes_left_next   = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        push           = 1'b1;
        push_data.kind = (rx_byte == END_BYTE) ? KIND_ACCEPT : KIND_REJECT;
        phase_next     = PH_HUNT;
        bytes_left_next = '0;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
    if (start_go) begin
      current_length_next = start_len;
      bytes_left_next     = start_len;
      phase_next          = (start_len == '0) ? PH_TAIL : PH_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      bytes_left     <= '0;
      current_length <= '0;
      length_mode    <= 1'b0;
      fixed_length   <= '0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        bytes_left     <= bytes_left_next;
        current_length <= current_length_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH_MODE:  length_mode  <= cfg_data[0];
          CFG_FIXED_LENGTH: fixed_length <= cfg_data[FRAME_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bfd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_fifo
// Short result queue between front and back, so that either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module bfd_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire bfd_pkg::bfd_result_t wr_data,
  input  wire logic                 rd_en,
  output bfd_pkg::bfd_result_t      rd_data,
  output bfd_pkg::bfd_qstat_t       status
);
  import bfd_pkg::*;

  bfd_result_t       entries [FIFO_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd_data      = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_back
// Back end: pops results from the queue into the output register and holds
// each one until the receiver takes the beat.
// ----------------------------------------------------------------------------
module bfd_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bfd_pkg::bfd_qstat_t          qstat,
  input  wire bfd_pkg::bfd_result_t         head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        item_kind,
  output logic [bfd_pkg::BYTE_W-1:0]        payload_byte,
  output logic [bfd_pkg::FRAME_LEN_W-1:0]   frame_length
);
  import bfd_pkg::*;

  // load whenever the output register is empty or being drained
  assign pop = !qstat.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_kind    <= head.kind;
      payload_byte <= head.payload;
      frame_length <= head.length;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/byte_frame_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_frame_deframer_unit
// Extracts framed payloads from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx_byte comes in on in_valid/in_stall, one byte per beat. Bytes are
//   dropped until the start byte, then the length (two bytes, low first, in
//   length mode; the fixed_length register otherwise), the payload and the
//   end byte follow. Each payload byte gives a payload item; the end byte
//   gives an accepted or rejected item carrying the frame length.
//   Results leave on out_valid/out_stall through an output register.
//   Registers are written on cfg_valid/cfg_ready; cfg_ready is always high.
//   Throughput: one byte per cycle while in_stall is low. A result is valid
//   once its byte has been written into the queue and then loaded into the
//   output register. A four entry result queue sits between the byte
//   tracker and the output register; in_stall rises only while that queue
//   is full, which happens only when the receiver stalls.
//   Reset clears the registers, returns to hunting for the start byte and
//   empties the queue.
// ----------------------------------------------------------------------------
module byte_frame_deframer_unit #(
  parameter int LENGTH_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bfd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           item_kind,
  output logic [bfd_pkg::BYTE_W-1:0]           payload_byte,
  output logic [bfd_pkg::FRAME_LEN_W-1:0]      frame_length,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfd_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  bfd_result_t push_data;
  bfd_result_t head;
  bfd_qstat_t  qstat;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign accept    = in_valid && !in_stall;

  bfd_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data)
  );

  bfd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && accept),
    .wr_data (push_data),
    .rd_en   (pop),
    .rd_data (head),
    .status  (qstat)
  );

  bfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length)
  );

`ifndef SYNTHESIS
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("result queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty result queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && accept && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
    else $error("result queue lost a write");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("output beat dropped while stalled");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_frame_deframer_unit. A driver sends received
// bytes from a queue and a monitor compares every result beat, in order,
// with the items that a behavioral tracker of the framing derives from the
// accepted bytes. Bytes cover hunting noise, zero and multi-byte lengths,
// bad end bytes and register changes inside a frame, in both length modes.
// ----------------------------------------------------------------------------
module testbench;
  import bfd_pkg::*;

  localparam int LEN_W       = 16;
  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [FRAME_LEN_W-1:0] LEN_MASK = FRAME_LEN_W'((32'd1 << LEN_W) - 1);
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = 8'hff;

  typedef enum logic [2:0] {
    SEEK_START,
    LEN_LOW,
    LEN_HIGH,
    IN_BODY,
    AT_TAIL
  } deframe_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      rx_byte   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             item_kind;
  logic [BYTE_W-1:0]      payload_byte;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // register copies and framing state of the tracker
  logic                   cfg_mode      = 1'b0;
  logic [FRAME_LEN_W-1:0] cfg_fixed_len = '0;
  deframe_state_t         trk_state     = SEEK_START;
  logic [FRAME_LEN_W-1:0] trk_left      = '0;
  logic [FRAME_LEN_W-1:0] trk_len       = '0;

  logic [BYTE_W-1:0] rx_pending[$];
  bfd_result_t       items_due[$];
  bfd_result_t       want;

  logic in_taken   = 1'b0;
  logic idle_on    = 1'b1;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   mismatches  = 0;
  int   bytes_sent  = 0;
  int   results_seen = 0;
  int   frames_ok  = 0;
  int   frames_bad = 0;
  int   reg_writes = 0;

  always #2 clk = ~clk;

  byte_frame_deframer_unit #(
    .LENGTH_WIDTH(LEN_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_kind   (item_kind),
    .payload_byte(payload_byte),
    .frame_length(frame_length),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [BYTE_W-1:0] body_byte();
    case ($urandom_range(0, 9))
      0:       return START_BYTE;
      1:       return END_BYTE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // never a start byte, so noise cannot open a frame
  function automatic logic [BYTE_W-1:0] stray_byte();
    logic [BYTE_W-1:0] v;
    v = ($urandom_range(0, 3) == 0) ? END_BYTE : BYTE_W'($urandom_range(0, 255));
    if (v == START_BYTE) v = 8'h00;
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] bad_tail();
    logic [BYTE_W-1:0] v;
    v = ($urandom_range(0, 2) == 0) ? START_BYTE : BYTE_W'($urandom_range(0, 255));
    if (v == END_BYTE) v = 8'h00;
    return v;
  endfunction

  task automatic open_body(input logic [FRAME_LEN_W-1:0] len);
    trk_len   = len & LEN_MASK;
    trk_left  = trk_len;
    trk_state = (trk_len == 0) ? AT_TAIL : IN_BODY;
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    bfd_result_t r;
    case (trk_state)
      LEN_LOW: begin
        if (LEN_W <= 8) begin
          open_body({8'h00, b});
        end else begin
          trk_len   = {8'h00, b};
          trk_state = LEN_HIGH;
        end
      end
      LEN_HIGH: open_body({b, trk_len[7:0]});
      IN_BODY: begin
        r.kind    = KIND_PAYLOAD;
        r.payload = b;
        r.length  = trk_len;
        items_due.push_back(r);
        trk_left = trk_left - 1'b1;
        if (trk_left == 0) trk_state = AT_TAIL;
      end
      AT_TAIL: begin
        r.kind    = (b == END_BYTE) ? KIND_ACCEPT : KIND_REJECT;
        r.payload = '0;
        r.length  = trk_len;
        items_due.push_back(r);
        trk_state = SEEK_START;
        trk_left  = '0;
      end
      default: begin
        trk_state = SEEK_START;
        if (b == START_BYTE) begin
          if (cfg_mode) begin
            trk_len   = '0;
            trk_left  = '0;
            trk_state = LEN_LOW;
          end else begin
            open_body(cfg_fixed_len);
          end
        end
      end
    endcase
  endtask

  // byte driver: a new beat only once the previous one has been taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (rx_pending.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte  <= rx_pending.pop_front();
        gap_left <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0) stall_left <= draw_gap();
    end
  end

  // tracker and result monitor
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      bytes_sent++;
      deframe_byte(rx_byte);
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (items_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d byte %02h length %0d",
                   item_kind, payload_byte, frame_length);
      end else begin
        want = items_due.pop_front();
        if (item_kind !== want.kind || payload_byte !== want.payload ||
            frame_length !== want.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected kind %0d byte %02h length %0d, got %0d %02h %0d",
                     results_seen, want.kind, want.payload, want.length,
                     item_kind, payload_byte, frame_length);
        end
        if (want.kind == KIND_ACCEPT) frames_ok++;
        if (want.kind == KIND_REJECT) frames_bad++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               items_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LENGTH_MODE) cfg_mode = val[0];
    else if (idx == CFG_FIXED_LENGTH) cfg_fixed_len = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender holds off until every byte is sent and every result is out, then idles
  task automatic wait_drained();
    do @(posedge clk); while (rx_pending.size() != 0 || in_valid || items_due.size() != 0);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  // length field is only sent in length mode, fixed mode uses the register
  task automatic queue_frame(input logic [FRAME_LEN_W-1:0] len_field, input bit good_tail);
    logic [FRAME_LEN_W-1:0] n;
    n = (cfg_mode ? len_field : cfg_fixed_len) & LEN_MASK;
    rx_pending.push_back(START_BYTE);
    if (cfg_mode) begin
      rx_pending.push_back(len_field[7:0]);
      if (LEN_W > 8) rx_pending.push_back(len_field[15:8]);
    end
    repeat (n) rx_pending.push_back(body_byte());
    rx_pending.push_back(good_tail ? END_BYTE : bad_tail());
  endtask

  initial begin : stimulus
    int p;
    int r;
    logic [FRAME_LEN_W-1:0] len;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: fixed mode, zero length
    rx_pending = '{8'h00, 8'hff, END_BYTE,
                   START_BYTE, END_BYTE,
                   START_BYTE, START_BYTE, END_BYTE};
    wait_drained();
    write_reg(CFG_FIXED_LENGTH, 16'd2);
    write_reg(CFG_NO_SUCH_REG, 16'h1234);
    rx_pending = '{START_BYTE, START_BYTE, 8'hff, END_BYTE};
    wait_drained();
    write_reg(CFG_LENGTH_MODE, 16'h0001);
    rx_pending = '{START_BYTE, 8'h00, 8'h00, END_BYTE,
                   START_BYTE, 8'h03, 8'h00, 8'h00, END_BYTE, START_BYTE, 8'h55,
                   START_BYTE, 8'h02, 8'h00, 8'haa};
    wait_drained();
    // registers change in the middle of a frame, the open frame keeps length 2
    write_reg(CFG_LENGTH_MODE, 16'hfffe);
    write_reg(CFG_FIXED_LENGTH, 16'd5);
    rx_pending = '{8'h55, END_BYTE};
    queue_frame('0, 1'b1);
    wait_drained();

    // length above one byte, sent without idling
    idle_on = 1'b0;
    write_reg(CFG_LENGTH_MODE, 16'h0001);
    queue_frame(16'h0105, 1'b0);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      idle_on = (p != 2);
      len = 16'($urandom);
      len[0] = p[0];
      write_reg(CFG_LENGTH_MODE, len);
      write_reg(CFG_FIXED_LENGTH, 16'($urandom_range(0, 12)));
      write_reg(CFG_NO_SUCH_REG - 8'(p), 16'($urandom));
      while (rx_pending.size() < 55) begin
        r = $urandom_range(0, 99);
        len = 16'($urandom_range(0, 12));
        if (r < 70) begin
          queue_frame(len, 1'b1);
        end else if (r < 82) begin
          queue_frame(len, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) rx_pending.push_back(stray_byte());
        end
      end
      wait_drained();
    end

    $display("%0d bytes sent, %0d result beats checked, %0d frames accepted, %0d rejected",
             bytes_sent, results_seen, frames_ok, frames_bad);
    $display("%0d register writes over both length modes, frame lengths from 0 to 261",
             reg_writes);
    if (mismatches == 0 && items_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, items_due.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
